[rtl/uqpt_pkg.sv]
// types, constants and helper functions for the url query pair tokenizer
package uqpt_pkg;

    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_EQUAL   = 8'h3D;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    localparam int POS_W  = 12;
    localparam int WPOS_W = 13;
    localparam int PIDX_W = 8;

    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_PAIR_SEP   = 2'd0;
    localparam t_cfg_idx CFG_ASSIGN     = 2'd1;
    localparam t_cfg_idx CFG_URL_DECODE = 2'd2;

    typedef enum logic [1:0] {
        ESC_IDLE,
        ESC_HIGH,
        ESC_LOW
    } t_esc;

    typedef enum logic [1:0] {
        PH_KEY_WAIT,
        PH_KEY,
        PH_VAL_WAIT,
        PH_VAL
    } t_phase;

    typedef struct packed {
        logic [7:0] pair_separator;
        logic [7:0] assign_char;
        logic       url_decode;
    } t_cfg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_byte;
    } t_item;

    // decoded byte handed from the escape stage to the parser
    typedef struct packed {
        logic       have;
        logic [7:0] raw;
        logic [7:0] dchar;
    } t_dec;

    typedef struct packed {
        logic              char_valid;
        logic [7:0]        decoded_char;
        logic [POS_W-1:0]  char_pos;
        logic              pair_valid;
        logic [PIDX_W-1:0] pair_index;
        logic [POS_W-1:0]  key_first;
        logic [POS_W-1:0]  key_last;
        logic [POS_W-1:0]  value_first;
        logic [POS_W-1:0]  value_last;
        logic              end_of_string;
        logic              overflow;
        logic              any_pair;
    } t_res;

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = c[3:0];
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            v = 4'(c[3:0] + 4'd9);
        end
        return v;
    endfunction

    function automatic logic [POS_W-1:0] sat12(input logic [WPOS_W-1:0] v);
        logic [POS_W-1:0] r;
        r = v[WPOS_W-1] ? {POS_W{1'b1}} : v[POS_W-1:0];
        return r;
    endfunction

endpackage

[rtl/uqpt_in_if.sv]
// input channel: raw string bytes with end marker
interface uqpt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       last_byte;

    modport source (output valid, output in_byte, output last_byte, input ready);
    modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface

[rtl/uqpt_out_if.sv]
// output channel: decoded byte and finished pair reports
interface uqpt_out_if;
    logic        valid;
    logic        ready;
    logic        char_valid;
    logic [7:0]  decoded_char;
    logic [11:0] char_pos;
    logic        pair_valid;
    logic [7:0]  pair_index;
    logic [11:0] key_first;
    logic [11:0] key_last;
    logic [11:0] value_first;
    logic [11:0] value_last;
    logic        end_of_string;
    logic        overflow;
    logic        any_pair;

    modport source (
        output valid, output char_valid, output decoded_char, output char_pos,
        output pair_valid, output pair_index, output key_first, output key_last,
        output value_first, output value_last, output end_of_string,
        output overflow, output any_pair, input ready
    );
    modport sink (
        input valid, input char_valid, input decoded_char, input char_pos,
        input pair_valid, input pair_index, input key_first, input key_last,
        input value_first, input value_last, input end_of_string,
        input overflow, input any_pair, output ready
    );
endinterface

[rtl/uqpt_in_reg.sv]
// input register stage holding one accepted byte
module uqpt_in_reg import uqpt_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_item i_item,
    output logic  o_ready,
    input  logic  i_take,
    output logic  o_valid,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

[rtl/uqpt_escape.sv]
// plus and percent escape decoder
module uqpt_escape import uqpt_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_fire,
    input  t_item i_item,
    input  logic  i_url_decode,
    output t_dec  o_dec
);

    t_esc       r_esc, n_esc;
    logic [3:0] r_high, n_high;
    logic [3:0] w_hex;

    assign w_hex = hex_val(i_item.in_byte);

    // next state
    always_comb begin
        n_esc  = r_esc;
        n_high = r_high;
        case (r_esc)
            ESC_IDLE: begin
                if (i_url_decode && i_item.in_byte == CH_PERCENT && !i_item.last_byte) begin
                    n_esc = ESC_HIGH;
                end
            end
            ESC_HIGH: begin
                n_esc  = ESC_LOW;
                n_high = w_hex;
            end
            ESC_LOW: begin
                n_esc = ESC_IDLE;
            end
            default: begin
                n_esc = ESC_IDLE;
            end
        endcase
        if (i_item.last_byte) begin
            n_esc  = ESC_IDLE;
            n_high = 4'd0;
        end
    end

    // outputs
    always_comb begin
        o_dec.have  = 1'b0;
        o_dec.raw   = CH_PERCENT;
        o_dec.dchar = 8'd0;
        case (r_esc)
            ESC_IDLE: begin
                if (i_url_decode && i_item.in_byte == CH_PERCENT) begin
                    // truncated escape at end of string decodes to zero
                    o_dec.have = i_item.last_byte;
                end else begin
                    o_dec.have  = 1'b1;
                    o_dec.raw   = i_item.in_byte;
                    o_dec.dchar = (i_url_decode && i_item.in_byte == CH_PLUS) ?
                                  CH_SPACE : i_item.in_byte;
                end
            end
            ESC_HIGH: begin
                o_dec.have  = i_item.last_byte;
                o_dec.dchar = {w_hex, 4'd0};
            end
            ESC_LOW: begin
                o_dec.have  = 1'b1;
                o_dec.dchar = {r_high, w_hex};
            end
            default: begin
                o_dec.have = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc  <= ESC_IDLE;
            r_high <= 4'd0;
        end else if (i_fire) begin
            r_esc  <= n_esc;
            r_high <= n_high;
        end
    end

endmodule

[rtl/uqpt_parser.sv]
// key/value boundary tracker and result builder
module uqpt_parser import uqpt_pkg::*; #(
    parameter int MAX_LEN   = 4096,
    parameter int MAX_PAIRS = 255
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_fire,
    input  logic i_last,
    input  t_dec i_dec,
    input  t_cfg i_cfg,
    output logic o_res_valid,
    output t_res o_res
);

    localparam int CAP      = (MAX_LEN < 4096) ? MAX_LEN : 4096;
    localparam int PAIR_CAP = (MAX_PAIRS < 255) ? MAX_PAIRS : 255;

    t_phase             r_phase, n_phase;
    logic [WPOS_W-1:0]  r_wpos, n_wpos;
    logic               r_fns_seen, n_fns_seen;
    logic [POS_W-1:0]   r_fns_pos, n_fns_pos;
    logic [POS_W-1:0]   r_kem, n_kem;
    logic [POS_W-1:0]   r_vb, n_vb;
    logic [PIDX_W-1:0]  r_pairs, n_pairs;
    logic               r_ovf, n_ovf;

    logic              w_stored, w_is_sep, w_is_as;
    logic [POS_W-1:0]  w_pos, w_pos_m1;
    logic              w_start_key, w_key_close, w_fns_hit, w_fns_cur;
    logic              w_pair_early, w_val_start, w_pair_val, w_pair_byte;
    logic              w_flush, w_pair;
    t_phase            w_p1, w_p2, w_p3, w_p4;
    logic [POS_W-1:0]  w_kl, w_kf_pick, w_kf, w_vf, w_vl, w_cnt_m1;

    assign w_stored = i_dec.have && (r_wpos < WPOS_W'(CAP));
    assign w_is_sep = i_dec.raw == i_cfg.pair_separator;
    assign w_is_as  = i_dec.raw == i_cfg.assign_char;
    assign w_pos    = r_wpos[POS_W-1:0];
    assign w_pos_m1 = w_pos - POS_W'(1);

    // phase walk for one byte, then next state
    always_comb begin
        w_start_key  = w_stored && r_phase == PH_KEY_WAIT && !w_is_sep && !w_is_as;
        w_p1         = w_start_key ? PH_KEY : r_phase;
        w_key_close  = w_stored && w_p1 == PH_KEY && w_is_as;
        w_fns_cur    = w_start_key ? 1'b0 : r_fns_seen;
        w_fns_hit    = w_stored && w_p1 == PH_KEY && !w_is_as && !w_fns_cur &&
                       i_dec.dchar != CH_SPACE;
        w_p2         = w_key_close ? PH_VAL_WAIT : w_p1;
        // same byte as separator and assign closes key and empty value together
        w_pair_early = w_stored && w_is_sep && w_p2 == PH_VAL_WAIT;
        w_val_start  = w_stored && !w_pair_early && w_p2 == PH_VAL_WAIT &&
                       !w_is_sep && !w_is_as;
        w_p3         = w_val_start ? PH_VAL : w_p2;
        w_pair_val   = w_stored && !w_pair_early && w_p3 == PH_VAL && w_is_sep;
        w_pair_byte  = w_pair_early || w_pair_val;
        w_p4         = w_pair_byte ? PH_KEY_WAIT : w_p3;

        n_wpos   = w_stored ? (r_wpos + WPOS_W'(1)) : r_wpos;
        w_flush  = i_last && !w_pair_byte && n_wpos != '0 && w_p4 != PH_KEY_WAIT;
        w_pair   = w_pair_byte || w_flush;
        n_phase  = i_last ? PH_KEY_WAIT : w_p4;

        n_fns_seen = w_fns_cur || w_fns_hit;
        n_fns_pos  = w_fns_hit ? w_pos : r_fns_pos;
        n_kem      = w_key_close ? w_pos_m1 : r_kem;
        n_vb       = w_val_start ? w_pos : r_vb;
        n_ovf      = r_ovf || (i_dec.have && !w_stored);
        n_pairs    = (w_pair && r_pairs < PIDX_W'(PAIR_CAP)) ? (r_pairs + PIDX_W'(1)) : r_pairs;
    end

    // outputs
    always_comb begin
        w_cnt_m1  = POS_W'(n_wpos - WPOS_W'(1));
        w_kl      = (w_flush && w_p4 == PH_KEY) ? w_cnt_m1 : n_kem;
        w_kf_pick = n_fns_seen ? n_fns_pos : w_kl;
        w_kf      = (w_kf_pick > w_kl) ? w_kl : w_kf_pick;
        w_vf      = '0;
        w_vl      = '0;
        if (w_pair_early) begin
            w_vf = w_pos;
            w_vl = w_pos_m1;
        end else if (w_pair_val) begin
            w_vf = n_vb;
            w_vl = w_pos_m1;
        end else if (w_flush) begin
            case (w_p4)
                PH_VAL: begin
                    w_vf = n_vb;
                    w_vl = w_cnt_m1;
                end
                PH_VAL_WAIT: begin
                    w_vf = w_cnt_m1;
                    w_vl = w_cnt_m1;
                end
                PH_KEY: begin
                    w_vf = sat12(n_wpos);
                    w_vl = sat12(n_wpos);
                end
                default: begin
                    w_vf = '0;
                    w_vl = '0;
                end
            endcase
        end

        o_res_valid          = w_stored || w_pair || i_last;
        o_res.char_valid     = w_stored;
        o_res.decoded_char   = (!w_stored || w_key_close || w_pair_byte) ? 8'd0 : i_dec.dchar;
        o_res.char_pos       = w_stored ? w_pos : '0;
        o_res.pair_valid     = w_pair;
        o_res.pair_index     = w_pair ? r_pairs : '0;
        o_res.key_first      = w_pair ? w_kf : '0;
        o_res.key_last       = w_pair ? w_kl : '0;
        o_res.value_first    = w_vf;
        o_res.value_last     = w_vl;
        o_res.end_of_string  = i_last;
        o_res.overflow       = n_ovf;
        o_res.any_pair       = n_pairs != '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_fire && i_last)) begin
            r_phase    <= PH_KEY_WAIT;
            r_wpos     <= '0;
            r_fns_seen <= 1'b0;
            r_fns_pos  <= '0;
            r_kem      <= '0;
            r_vb       <= '0;
            r_pairs    <= '0;
            r_ovf      <= 1'b0;
        end else if (i_fire) begin
            r_phase    <= n_phase;
            r_wpos     <= n_wpos;
            r_fns_seen <= n_fns_seen;
            r_fns_pos  <= n_fns_pos;
            r_kem      <= n_kem;
            r_vb       <= n_vb;
            r_pairs    <= n_pairs;
            r_ovf      <= n_ovf;
        end
    end

    a_restart_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_last |=> r_wpos == '0 && r_phase == PH_KEY_WAIT && r_pairs == '0)
        else $error("parser state not cleared after end of string");

    a_wpos_in_capacity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wpos <= WPOS_W'(CAP))
        else $error("write position beyond capacity");

endmodule

[rtl/url_query_pair_tokenizer.sv]
// top level: input register, escape decoder, parser and result register
// a byte is first held in the input register, then its result is registered in the output register
// throughput: one byte per cycle while the result register is free or draining, limited by the parser state update
// bytes that produce no result (escape prefix, first digit, bytes past capacity) are consumed but emit nothing
// reset: synchronous active low, clears parser state and restores '&', '=' and decoding on
module url_query_pair_tokenizer import uqpt_pkg::*; #(
    parameter int MAX_LEN   = 4096,
    parameter int MAX_PAIRS = 255
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_cfg_we,
    input  t_cfg_idx i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    uqpt_in_if.sink    i_in,
    uqpt_out_if.source o_res
);

    t_cfg  r_cfg;
    t_item w_in_item, w_item;
    logic  w_item_valid, w_fire;
    t_dec  w_dec;
    logic  w_res_valid;
    t_res  w_res;
    logic  r_out_valid;
    t_res  r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pair_separator <= CH_AMP;
            r_cfg.assign_char    <= CH_EQUAL;
            r_cfg.url_decode     <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PAIR_SEP:   r_cfg.pair_separator <= i_cfg_data;
                CFG_ASSIGN:     r_cfg.assign_char    <= i_cfg_data;
                CFG_URL_DECODE: r_cfg.url_decode     <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign w_in_item.in_byte   = i_in.in_byte;
    assign w_in_item.last_byte = i_in.last_byte;

    // a byte moves on whenever the result register is free or draining
    assign w_fire = w_item_valid && (!r_out_valid || o_res.ready);

    uqpt_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .i_item  (w_in_item),
        .o_ready (i_in.ready),
        .i_take  (w_fire),
        .o_valid (w_item_valid),
        .o_item  (w_item)
    );

    uqpt_escape u_escape (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (w_fire),
        .i_item       (w_item),
        .i_url_decode (r_cfg.url_decode),
        .o_dec        (w_dec)
    );

    uqpt_parser #(
        .MAX_LEN   (MAX_LEN),
        .MAX_PAIRS (MAX_PAIRS)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_fire),
        .i_last      (w_item.last_byte),
        .i_dec       (w_dec),
        .i_cfg       (r_cfg),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= w_res_valid;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_res_valid) begin
            r_res <= w_res;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.char_valid    = r_res.char_valid;
    assign o_res.decoded_char  = r_res.decoded_char;
    assign o_res.char_pos      = r_res.char_pos;
    assign o_res.pair_valid    = r_res.pair_valid;
    assign o_res.pair_index    = r_res.pair_index;
    assign o_res.key_first     = r_res.key_first;
    assign o_res.key_last      = r_res.key_last;
    assign o_res.value_first   = r_res.value_first;
    assign o_res.value_last    = r_res.value_last;
    assign o_res.end_of_string = r_res.end_of_string;
    assign o_res.overflow      = r_res.overflow;
    assign o_res.any_pair      = r_res.any_pair;

    a_key_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.pair_valid |-> o_res.key_first <= o_res.key_last)
        else $error("pair reported with key start after key end");

    a_no_pair_any: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.pair_valid |-> o_res.any_pair)
        else $error("pair reported without any_pair set");

endmodule
